// ===== src/clock_time_range_parser_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the clock time range parser unit
// Shared helpers for concurrent checks clocked on clk_i, gated by rst_ni.
// ---------------------------------------------------------------------------
`ifndef CLOCK_TIME_RANGE_PARSER_UNIT_ASSERT_SVH
`define CLOCK_TIME_RANGE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CTRP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ctrp_pkg.sv =====
// ---------------------------------------------------------------------------
// ctrp_pkg
// Types, constants and the part evaluation function of the time parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ctrp_pkg;

  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic        REG_RANGE_MODE = 1'b0;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  localparam int unsigned MAX_HOUR     = 24;
  localparam int unsigned MAX_MINUTE   = 59;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned MINS_PER_HR  = 60;
  localparam int unsigned PART_DIGITS  = 4;
  localparam int unsigned PART_LEN_MAX = 5;

  typedef enum logic [3:0] {
    ERR_OK              = 4'd0,
    ERR_NO_DASH         = 4'd1,
    ERR_LENGTH          = 4'd2,
    ERR_HOUR_NONDIGIT   = 4'd3,
    ERR_HOUR_BIG        = 4'd4,
    ERR_MINUTE_NONDIGIT = 4'd5,
    ERR_MINUTE_BIG      = 4'd6,
    ERR_HOUR24_MINUTES  = 4'd7,
    ERR_ORDER           = 4'd8
  } err_e;

  typedef logic [3:0][3:0] digits_t;

  // Classified character as it travels from the front to the back.
  typedef struct packed {
    logic       split;     // the dash that ends the start part
    logic       last;
    logic       mode;      // range_mode sampled with the character
    logic       nondigit;
    logic [3:0] digit;
  } tok_t;

  typedef struct packed {
    err_e       err;
    logic [4:0] hour;
    logic [5:0] minute;
  } part_res_t;

  typedef struct packed {
    err_e        err;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [4:0]  stop_hour;
    logic [5:0]  stop_minute;
    logic [16:0] range_seconds;
  } res_t;

  // Places the stored characters by part length and runs the checks in order.
  function automatic part_res_t eval_part(digits_t d, logic [3:0] nd, logic [2:0] len);
    digits_t    p;
    logic [3:0] n;
    logic [6:0] h;
    logic [6:0] m;
    part_res_t  r;
    p        = '0;
    n        = '0;
    r.err    = ERR_OK;
    r.hour   = '0;
    r.minute = '0;
    unique case (len)
      3'd1: begin
        p[1] = d[0];
        n[1] = nd[0];
      end
      3'd2: begin
        p[1:0] = d[1:0];
        n[1:0] = nd[1:0];
      end
      3'd3: begin
        p[3:1] = d[2:0];
        n[3:1] = nd[2:0];
      end
      3'd4: begin
        p = d;
        n = nd;
      end
      default: r.err = ERR_LENGTH;
    endcase
    h = 7'd10 * {3'b000, p[0]} + {3'b000, p[1]};
    m = 7'd10 * {3'b000, p[2]} + {3'b000, p[3]};
    priority if (r.err != ERR_OK) begin
      r.err = ERR_LENGTH;
    end else if (n[0] | n[1]) begin
      r.err = ERR_HOUR_NONDIGIT;
    end else if (h > 7'(MAX_HOUR)) begin
      r.err = ERR_HOUR_BIG;
    end else if (n[2] | n[3]) begin
      r.err = ERR_MINUTE_NONDIGIT;
    end else if (m > 7'(MAX_MINUTE)) begin
      r.err = ERR_MINUTE_BIG;
    end else if ((h == 7'(MAX_HOUR)) && (m != 7'd0)) begin
      r.err = ERR_HOUR24_MINUTES;
    end else begin
      r.hour   = h[4:0];
      r.minute = m[5:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ctrp_front.sv =====
// ---------------------------------------------------------------------------
// ctrp_front
// Accepts characters, classifies them and tracks the splitting dash.
// ---------------------------------------------------------------------------
`default_nettype none

module ctrp_front import ctrp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       last_char_i,
  input  wire logic       range_mode_i,
  input  wire logic       q_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output tok_t            tok_o
);

  logic dash_seen_q, dash_seen_d;
  logic is_digit;

  assign is_digit   = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    tok_o.split    = range_mode_i && !dash_seen_q && (char_code_i == CHAR_DASH);
    tok_o.last     = last_char_i;
    tok_o.mode     = range_mode_i;
    tok_o.nondigit = !is_digit;
    tok_o.digit    = is_digit ? 4'(char_code_i - CHAR_ZERO) : 4'd0;
  end

  // Only the first dash of a range splits; the end of the text rearms it.
  always_comb begin
    dash_seen_d = dash_seen_q;
    if (push_o) begin
      if (last_char_i) begin
        dash_seen_d = 1'b0;
      end else if (tok_o.split) begin
        dash_seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_seen_q <= 1'b0;
    end else begin
      dash_seen_q <= dash_seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ctrp_queue.sv =====
// ---------------------------------------------------------------------------
// ctrp_queue
// Short first-in first-out queue of classified characters.
// ---------------------------------------------------------------------------
`default_nettype none

module ctrp_queue import ctrp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire tok_t tok_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output tok_t      tok_o
);

  tok_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ctrp_back.sv =====
// ---------------------------------------------------------------------------
// ctrp_back
// Builds the current part, holds the start outcome and forms the result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "clock_time_range_parser_unit_assert.svh"

module ctrp_back import ctrp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tok_valid_i,
  input  wire tok_t tok_i,
  output logic      pop_o,
  input  wire logic out_stall_i,
  output logic      out_valid_o,
  output res_t      res_o
);

  digits_t    dig_q, dig_d;
  logic [3:0] nd_q, nd_d;
  logic [2:0] len_q, len_d;
  logic       dash_q, dash_d;
  logic [4:0] held_h_q, held_h_d;
  logic [5:0] held_m_q, held_m_d;
  err_e       held_err_q, held_err_d;
  logic       out_valid_q, out_valid_d;
  res_t       res_q, res_d;
  part_res_t  start_res, part_res;
  logic [10:0] t0, t1, diff;

  assign pop_o       = tok_valid_i && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign start_res = eval_part(dig_q, nd_q, len_q);

  // Part state after this character.
  always_comb begin
    dig_d      = dig_q;
    nd_d       = nd_q;
    len_d      = len_q;
    dash_d     = dash_q;
    held_h_d   = held_h_q;
    held_m_d   = held_m_q;
    held_err_d = held_err_q;
    if (tok_i.split) begin
      held_h_d   = start_res.hour;
      held_m_d   = start_res.minute;
      held_err_d = start_res.err;
      dash_d     = 1'b1;
      dig_d      = '0;
      nd_d       = '0;
      len_d      = '0;
    end else begin
      if (len_q < 3'(PART_DIGITS)) begin
        dig_d[len_q[1:0]] = tok_i.digit;
        nd_d[len_q[1:0]]  = tok_i.nondigit;
      end
      if (len_q < 3'(PART_LEN_MAX)) begin
        len_d = len_q + 3'd1;
      end
    end
  end

  assign part_res = eval_part(dig_d, nd_d, len_d);
  assign t0       = 11'(held_h_d) * 11'(MINS_PER_HR) + 11'(held_m_d);
  assign t1       = 11'(part_res.hour) * 11'(MINS_PER_HR) + 11'(part_res.minute);
  assign diff     = t1 - t0;

  always_comb begin
    res_d = '0;
    if (tok_i.mode) begin
      priority if (!dash_d) begin
        res_d.err = ERR_NO_DASH;
      end else if (held_err_d != ERR_OK) begin
        res_d.err = held_err_d;
      end else if (part_res.err != ERR_OK) begin
        res_d.err = part_res.err;
      end else if (t0 >= t1) begin
        res_d.err = ERR_ORDER;
      end else begin
        res_d.err           = ERR_OK;
        res_d.start_hour    = held_h_d;
        res_d.start_minute  = held_m_d;
        res_d.stop_hour     = part_res.hour;
        res_d.stop_minute   = part_res.minute;
        res_d.range_seconds = 17'(diff) * 17'(SECS_PER_MIN);
      end
    end else begin
      res_d.err          = part_res.err;
      res_d.start_hour   = part_res.hour;
      res_d.start_minute = part_res.minute;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && tok_i.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && tok_i.last) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q       <= '0;
      nd_q        <= '0;
      len_q       <= '0;
      dash_q      <= 1'b0;
      held_h_q    <= '0;
      held_m_q    <= '0;
      held_err_q  <= ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        if (tok_i.last) begin
          dig_q      <= '0;
          nd_q       <= '0;
          len_q      <= '0;
          dash_q     <= 1'b0;
          held_h_q   <= '0;
          held_m_q   <= '0;
          held_err_q <= ERR_OK;
        end else begin
          dig_q      <= dig_d;
          nd_q       <= nd_d;
          len_q      <= len_d;
          dash_q     <= dash_d;
          held_h_q   <= held_h_d;
          held_m_q   <= held_m_d;
          held_err_q <= held_err_d;
        end
      end
    end
  end

  `CTRP_ASSERT_IMPL(a_err_zero_fields,
    out_valid_q && (res_q.err != ERR_OK),
    (res_q.start_hour == '0) && (res_q.start_minute == '0) && (res_q.stop_hour == '0) &&
    (res_q.stop_minute == '0) && (res_q.range_seconds == '0),
    "ctrp_back: result fields not zero on error")
  `CTRP_ASSERT_IMPL(a_len_sat, 1'b1, len_q <= 3'(PART_LEN_MAX),
    "ctrp_back: part length beyond saturation")
  `CTRP_ASSERT_IMPL(a_no_pop_blocked, pop_o, !(out_valid_q && out_stall_i),
    "ctrp_back: item taken while a result is blocked")
  `CTRP_ASSERT_NEXT(a_last_clears, pop_o && tok_i.last,
    (len_q == '0) && !dash_q && (held_err_q == ERR_OK),
    "ctrp_back: state not cleared after the last character")

endmodule

`default_nettype wire

// ===== src/clock_time_range_parser_unit.sv =====
// ---------------------------------------------------------------------------
// clock_time_range_parser_unit
// Parses a clock time or a start-dash-stop time range from a byte stream.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i/in_stall_o   char_code_i, last_char_i
//   output    out        out_valid_o/out_stall_i error_code_o, start/stop times,
//                                                range_seconds_o
//   config    in         psel/penable/pwrite     range_mode at byte address 0
//
// One character request is taken per cycle while the queue is not full; the
// result of a text is ready in the cycle after its last character is accepted
// by the back end; a character from the input port passes the queue first.
// While a result is blocked the back end takes no requests, so the two-entry
// queue fills and then stalls the input.
// Reset clears the parse state, the queue and the output valid, and sets
// range_mode to one. No clearing pass is needed after reset.
//
`default_nettype none

module clock_time_range_parser_unit import ctrp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Character requests.
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  last_char_i,
  // Results.
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [3:0]                 error_code_o,
  output logic [4:0]                 start_hour_o,
  output logic [5:0]                 start_minute_o,
  output logic [4:0]                 stop_hour_o,
  output logic [5:0]                 stop_minute_o,
  output logic [16:0]                range_seconds_o,
  // Register port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic range_mode_q, range_mode_d;
  logic reg_write, reg_hit;

  logic q_full, q_valid, push, pop;
  tok_t front_tok, queue_tok;
  res_t res;

  // The register port has no wait states. Word index is paddr[2]; the low
  // byte-offset bits are ignored.
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[2] == REG_RANGE_MODE);
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    range_mode_d = range_mode_q;
    if (reg_write && reg_hit) begin
      range_mode_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[0] = range_mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_mode_q <= 1'b1;
    end else begin
      range_mode_q <= range_mode_d;
    end
  end

  // Front end: classifies each character and marks the splitting dash, so the
  // back end sees a self-contained request that carries its own mode bit.
  ctrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .range_mode_i (range_mode_q),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .tok_o        (front_tok)
  );

  // The queue decouples the two ends so each can stall on its own.
  ctrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (front_tok),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .tok_o   (queue_tok)
  );

  // Back end: accumulates the part, fixes the start outcome on the dash and
  // evaluates the complete text on its last character.
  ctrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (queue_tok),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign error_code_o    = res.err;
  assign start_hour_o    = res.start_hour;
  assign start_minute_o  = res.start_minute;
  assign stop_hour_o     = res.stop_hour;
  assign stop_minute_o   = res.stop_minute;
  assign range_seconds_o = res.range_seconds;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Clock time range parser testbench
// Sends character requests holding clock times and start-dash-stop ranges,
// predicts each result with its own copy of the parse state, and checks every
// result field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------

module testbench import ctrp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the pipeline settle once nothing is expected any more.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Length of the deliberate receiver hold-off that backs up the block.
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [APB_ADDR_W-1:0] MODE_ADDR = APB_ADDR_W'(4 * REG_RANGE_MODE);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_req_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs, all known from time zero.
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [7:0]            char_code_i = '0;
  logic                  last_char_i = 1'b0;
  logic                  out_stall_i = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [3:0]            error_code_o;
  logic [4:0]            start_hour_o;
  logic [5:0]            start_minute_o;
  logic [4:0]            stop_hour_o;
  logic [5:0]            stop_minute_o;
  logic [16:0]           range_seconds_o;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  always #1ns clk_i = ~clk_i;

  clock_time_range_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .last_char_i     (last_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .error_code_o    (error_code_o),
    .start_hour_o    (start_hour_o),
    .start_minute_o  (start_minute_o),
    .stop_hour_o     (stop_hour_o),
    .stop_minute_o   (stop_minute_o),
    .range_seconds_o (range_seconds_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // --------------------------------------------------------------------------
  // Shared bench state. The stimulus process only touches the queues and the
  // control flags at the falling edge, so the clocked driver and monitor never
  // race with it.
  // --------------------------------------------------------------------------
  char_req_t   char_req_q[$];      // character requests not yet offered
  res_t        parse_result_q[$];  // results owed by texts already sent
  logic [7:0]  text_buf[$];        // text being assembled
  int unsigned fail_count  = 0;
  bit          no_idle     = 1'b0; // suppresses random gaps and stalls
  int unsigned hold_asks   = 0;
  int unsigned holds_done  = 0;
  bit          hold_active = 1'b0; // receiver is in its long hold-off

  // Predictor state: a private copy of what the parser keeps between requests.
  logic        mode_setting = 1'b1;
  logic [3:0]  part_digits[4];
  logic [3:0]  part_bad;
  logic [2:0]  part_len;
  logic        split_seen;
  err_e        first_err;
  logic [4:0]  first_hour;
  logic [5:0]  first_minute;

  function automatic void clear_part();
    for (int i = 0; i < 4; i++) begin
      part_digits[i] = '0;
    end
    part_bad = '0;
    part_len = '0;
  endfunction

  // Places the characters of the current part by its length, then runs the
  // checks in their fixed order. Hour and minute stay zero on any error.
  function automatic void grade_part(output err_e err, output logic [4:0] hr,
                                     output logic [5:0] mn);
    logic [3:0]  pos[4];
    logic [3:0]  bad;
    int unsigned shift;
    int unsigned hv;
    int unsigned mv;
    err = ERR_OK;
    hr  = '0;
    mn  = '0;
    bad = '0;
    for (int i = 0; i < 4; i++) begin
      pos[i] = '0;
    end
    if (part_len == 0 || part_len > PART_DIGITS) begin
      err = ERR_LENGTH;
      return;
    end
    // Odd lengths have a single hour digit, so they fill from position one.
    shift = part_len[0] ? 1 : 0;
    for (int i = 0; i < part_len; i++) begin
      pos[i + shift] = part_digits[i];
      bad[i + shift] = part_bad[i];
    end
    hv = 10 * pos[0] + pos[1];
    mv = 10 * pos[2] + pos[3];
    if (bad[0] | bad[1]) begin
      err = ERR_HOUR_NONDIGIT;
    end else if (hv > MAX_HOUR) begin
      err = ERR_HOUR_BIG;
    end else if (bad[2] | bad[3]) begin
      err = ERR_MINUTE_NONDIGIT;
    end else if (mv > MAX_MINUTE) begin
      err = ERR_MINUTE_BIG;
    end else if (hv == MAX_HOUR && mv != 0) begin
      err = ERR_HOUR24_MINUTES;
    end else begin
      hr = 5'(hv);
      mn = 6'(mv);
    end
  endfunction

  // Advances the predicted parse by one accepted character and, on the last
  // character of a text, queues the result it must produce.
  function automatic void parse_char(logic [7:0] code, logic is_last);
    res_t        r;
    err_e        e;
    logic [4:0]  hr;
    logic [5:0]  mn;
    int unsigned t0;
    int unsigned t1;
    if (mode_setting && !split_seen && code == CHAR_DASH) begin
      grade_part(first_err, first_hour, first_minute);
      split_seen = 1'b1;
      clear_part();
    end else begin
      if (part_len < PART_DIGITS) begin
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
          part_digits[part_len] = 4'(code - CHAR_ZERO);
        end else begin
          part_digits[part_len] = '0;
          part_bad[part_len]    = 1'b1;
        end
      end
      if (part_len < PART_LEN_MAX) begin
        part_len++;
      end
    end
    if (!is_last) begin
      return;
    end
    r = '0;
    if (mode_setting) begin
      if (!split_seen) begin
        r.err = ERR_NO_DASH;
      end else if (first_err != ERR_OK) begin
        r.err = first_err;
      end else begin
        grade_part(e, hr, mn);
        t0 = first_hour * MINS_PER_HR + first_minute;
        t1 = hr * MINS_PER_HR + mn;
        if (e != ERR_OK) begin
          r.err = e;
        end else if (t0 >= t1) begin
          r.err = ERR_ORDER;
        end else begin
          r.start_hour    = first_hour;
          r.start_minute  = first_minute;
          r.stop_hour     = hr;
          r.stop_minute   = mn;
          r.range_seconds = 17'((t1 - t0) * SECS_PER_MIN);
        end
      end
    end else begin
      grade_part(e, hr, mn);
      r.err          = e;
      r.start_hour   = hr;
      r.start_minute = mn;
    end
    parse_result_q.push_back(r);
    clear_part();
    split_seen   = 1'b0;
    first_err    = ERR_OK;
    first_hour   = '0;
    first_minute = '0;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned draw_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers character requests from the pending queue, holds a stalled
  // request unchanged, and feeds every accepted request to the predictor.
  // --------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    char_req_t req;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      char_code_i <= '0;
      last_char_i <= 1'b0;
      gap_left    = 0;
      clear_part();
      split_seen   = 1'b0;
      first_err    = ERR_OK;
      first_hour   = '0;
      first_minute = '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(char_code_i, last_char_i);
      end
      if (in_valid_i && in_stall_o) begin
        // Stalled: the request stays on the port as it is.
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (char_req_q.size() > 0) begin
        req = char_req_q.pop_front();
        in_valid_i  <= 1'b1;
        char_code_i <= req.code;
        last_char_i <= req.last;
        gap_left    = draw_pause();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: counts the cycles of a requested receiver hold-off.
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left   = 0;
      hold_active <= 1'b0;
    end else begin
      if (hold_asks != holds_done) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_active <= 1'b1;
      end else begin
        hold_active <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every accepted result against the oldest expectation and
  // drives the result stall, holding it during the long hold-off.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    res_t seen;
    res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen.err           = err_e'(error_code_o);
        seen.start_hour    = start_hour_o;
        seen.start_minute  = start_minute_o;
        seen.stop_hour     = stop_hour_o;
        seen.stop_minute   = stop_minute_o;
        seen.range_seconds = range_seconds_o;
        if (parse_result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: result with no text pending: err %0d start %0d:%0d",
                     $realtime, seen.err, seen.start_hour, seen.start_minute);
          end
        end else begin
          want = parse_result_q.pop_front();
          if (seen.err !== want.err || seen.start_hour !== want.start_hour ||
              seen.start_minute !== want.start_minute ||
              seen.stop_hour !== want.stop_hour ||
              seen.stop_minute !== want.stop_minute ||
              seen.range_seconds !== want.range_seconds) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: mismatch, expected err %0d %0d:%0d-%0d:%0d span %0d",
                       $realtime, want.err, want.start_hour, want.start_minute,
                       want.stop_hour, want.stop_minute, want.range_seconds);
              $display("%0t:                got err %0d %0d:%0d-%0d:%0d span %0d",
                       $realtime, seen.err, seen.start_hour, seen.start_minute,
                       seen.stop_hour, seen.stop_minute, seen.range_seconds);
            end
          end
        end
      end
      if (hold_active) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = draw_pause();
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) begin
          stall_left--;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic void queue_char(logic [7:0] code, logic is_last);
    char_req_t req;
    req.code = code;
    req.last = is_last;
    char_req_q.push_back(req);
  endfunction

  // Queues a text; with ends cleared the text is left open for more.
  function automatic void queue_text(string s, bit ends = 1'b1);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], ends && (i == s.len() - 1));
    end
  endfunction

  function automatic void queue_text_buf();
    for (int i = 0; i < text_buf.size(); i++) begin
      queue_char(text_buf[i], i == text_buf.size() - 1);
    end
    text_buf.delete();
  endfunction

  // Appends one time part. Most parts are well-formed times in one of the four
  // layouts, some carry out-of-range values, the rest are random noise.
  function automatic void add_time_part();
    int unsigned kind;
    int unsigned hr;
    int unsigned mn;
    int unsigned len;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      hr = $urandom_range(0, (kind < 62) ? MAX_HOUR : 29);
      mn = $urandom_range(0, (kind < 62) ? MAX_MINUTE : 99);
      if ((hr == MAX_HOUR && kind < 50) || $urandom_range(0, 3) == 0) begin
        mn = 0;
      end
      if (mn == 0 && $urandom_range(0, 1) == 1) begin
        len = (hr < 10 && $urandom_range(0, 1) == 1) ? 1 : 2;
      end else begin
        len = (hr < 10 && $urandom_range(0, 1) == 1) ? 3 : 4;
      end
      if (len == 2 || len == 4) begin
        text_buf.push_back(CHAR_ZERO + 8'(hr / 10));
      end
      text_buf.push_back(CHAR_ZERO + 8'(hr % 10));
      if (len > 2) begin
        text_buf.push_back(CHAR_ZERO + 8'(mn / 10));
        text_buf.push_back(CHAR_ZERO + 8'(mn % 10));
      end
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        if (kind < 88 && $urandom_range(0, 3) != 0) begin
          text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end else begin
          text_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endfunction

  // Waits at falling edges until no request is pending or in flight and no
  // result is owed, then lets the pipeline settle.
  task automatic wait_idle();
    while (char_req_q.size() != 0 || in_valid_i || parse_result_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle; pready is always high.
  // The upper data bits are random since only bit zero holds the mode.
  task automatic write_range_mode(logic m);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'($urandom()), m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mode_setting = m;
    @(negedge clk_i);
  endtask

  // A phase of random texts under one mode setting. With pressure set, the
  // receiver holds off for a long stretch at the start, and halfway through
  // the sender waits until every owed result has come back.
  task automatic run_phase(logic m, bit calm, bit pressure);
    int unsigned sent;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    write_range_mode(m);
    no_idle = calm;
    if (pressure) begin
      hold_asks++;
    end
    while (sent < PHASE_ITEMS) begin
      if (pressure && !paused && sent >= PHASE_ITEMS / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      add_time_part();
      if (m) begin
        text_buf.push_back(CHAR_DASH);
        add_time_part();
      end
      if (text_buf.size() == 0) begin
        text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      sent += text_buf.size();
      queue_text_buf();
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed texts, random phases, final verdict.
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Range mode straight out of reset.
    queue_text("0-24");        // widest range, a full day
    queue_text("0059-2400");   // four-digit layouts at the extremes
    queue_text("7");           // no dash at all
    queue_text("-");           // empty start part
    queue_text("12-");         // dash as the last character, empty stop part
    queue_text("1a-2");        // letter in an hour position
    queue_text("25-3");        // hour above 24
    queue_text("1x5-2");       // letter in a minute position
    queue_text("960-23");      // minute above 59
    queue_text("2401-1");      // hour 24 with minutes
    queue_text("9-9");         // start equal to stop
    queue_text("1-2-3");       // a second dash belongs to the stop part
    queue_text("12345-1");     // start part too long
    queue_char(8'h00, 1'b0);   // character code zero is a plain non-digit
    queue_text("-1");
    queue_text("10-", 1'b0);   // left open while the mode changes below
    wait_idle();

    // Mode changed mid-text: only the current part is parsed as one time.
    write_range_mode(1'b0);
    queue_text("0930");
    queue_text("2400");        // largest single time
    queue_text("0");
    queue_text("-5");          // dash is an ordinary non-digit here
    queue_text("123456");      // part longer than five saturates the count
    queue_char(8'hFF, 1'b1);   // all ones code as a lone character
    wait_idle();

    run_phase(1'b1, 1'b0, 1'b1);
    run_phase(1'b0, 1'b0, 1'b0);
    run_phase(1'b1, 1'b1, 1'b0);
    run_phase(1'b0, 1'b0, 1'b0);

    if (parse_result_q.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
